>>> hw/rtl/ycbcr_to_rgb_screen_enhance_defines.svh
// Assertion helpers for the yrse_chk checker.
`ifndef YCBCR_TO_RGB_SCREEN_ENHANCE_DEFINES_SVH
`define YCBCR_TO_RGB_SCREEN_ENHANCE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define YRSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define YRSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/yrse_pkg.sv
`default_nettype none
package yrse_pkg;

  // Q10 conversion coefficients
  localparam int unsigned CoefW = 13;
  localparam logic signed [CoefW-1:0] QY  = 13'sd1192;
  localparam logic signed [CoefW-1:0] QRV = 13'sd1634;
  localparam logic signed [CoefW-1:0] QGV = 13'sd833;
  localparam logic signed [CoefW-1:0] QGU = 13'sd401;
  localparam logic signed [CoefW-1:0] QBU = 13'sd2065;

  localparam logic signed [8:0] YOffset = 9'sd16;
  localparam logic signed [8:0] COffset = 9'sd128;

  localparam int unsigned ProdW = 20;
  localparam int unsigned SumW  = 22;
  localparam int unsigned FracW = 10;

  localparam logic [1:0] PassesMax   = 2'd2;
  localparam logic [1:0] PassesReset = 2'd2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // pixel plus the number of brightening passes still to run
  typedef struct packed {
    pix_t       pix;
    logic [1:0] n;
  } beat_t;

endpackage
`default_nettype wire

>>> hw/rtl/yrse_in_if.sv
`default_nettype none
interface yrse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/yrse_out_if.sv
`default_nettype none
interface yrse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/yrse_csc.sv
`default_nettype none
// Color space conversion: products, then sum / truncate / saturate.
module yrse_csc (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  yrse_in_if.sink               pix_i,
  input  wire logic [1:0]       passes_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output yrse_pkg::beat_t       beat_o
);

  logic signed [8:0] y_s, cb_s, cr_s;
  logic [1:0]        n_in;

  logic                                 s1_v_q;
  logic signed [yrse_pkg::ProdW-1:0]    py_q, prv_q, pgv_q, pgu_q, pbu_q;
  logic [1:0]                           s1_n_q;
  logic                                 s1_ready;

  logic                                 s2_v_q;
  yrse_pkg::beat_t                      s2_beat_q;
  logic                                 s2_ready;

  logic signed [yrse_pkg::SumW-1:0]     sum_r, sum_g, sum_b;
  yrse_pkg::pix_t                       pix_d;

  assign y_s  = $signed({1'b0, pix_i.luma}) - yrse_pkg::YOffset;
  assign cb_s = $signed({1'b0, pix_i.chroma_blue}) - yrse_pkg::COffset;
  assign cr_s = $signed({1'b0, pix_i.chroma_red}) - yrse_pkg::COffset;
  // a count of 3 acts as the maximum
  assign n_in = (passes_i > yrse_pkg::PassesMax) ? yrse_pkg::PassesMax : passes_i;

  assign s2_ready    = !s2_v_q || ready_i;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign pix_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pix_i.valid) begin
      py_q   <= yrse_pkg::ProdW'(y_s) * yrse_pkg::ProdW'(yrse_pkg::QY);
      prv_q  <= yrse_pkg::ProdW'(cr_s) * yrse_pkg::ProdW'(yrse_pkg::QRV);
      pgv_q  <= yrse_pkg::ProdW'(cr_s) * yrse_pkg::ProdW'(yrse_pkg::QGV);
      pgu_q  <= yrse_pkg::ProdW'(cb_s) * yrse_pkg::ProdW'(yrse_pkg::QGU);
      pbu_q  <= yrse_pkg::ProdW'(cb_s) * yrse_pkg::ProdW'(yrse_pkg::QBU);
      s1_n_q <= n_in;
    end
  end

  assign sum_r = yrse_pkg::SumW'(py_q) + yrse_pkg::SumW'(prv_q);
  assign sum_g = yrse_pkg::SumW'(py_q) - yrse_pkg::SumW'(pgv_q) - yrse_pkg::SumW'(pgu_q);
  assign sum_b = yrse_pkg::SumW'(py_q) + yrse_pkg::SumW'(pbu_q);

  function automatic logic [7:0] sat_q10(logic signed [yrse_pkg::SumW-1:0] s);
    logic [7:0] v;
    // negative sums truncate to zero or below, both clamp to 0
    if (s < 0) begin
      v = 8'd0;
    end else if (s[yrse_pkg::SumW-1:yrse_pkg::FracW+8] != '0) begin
      v = 8'd255;
    end else begin
      v = s[yrse_pkg::FracW+7:yrse_pkg::FracW];
    end
    return v;
  endfunction

  always_comb begin
    pix_d.r = sat_q10(sum_r);
    pix_d.g = sat_q10(sum_g);
    pix_d.b = sat_q10(sum_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_beat_q.pix <= pix_d;
      s2_beat_q.n   <= s1_n_q;
    end
  end

  assign valid_o = s2_v_q;
  assign beat_o  = s2_beat_q;

endmodule
`default_nettype wire

>>> hw/rtl/yrse_pass.sv
`default_nettype none
// One screen brightening pass: scale by (255 - G), then screen blend.
// Skipped (data passes unchanged) when no passes remain for the word.
module yrse_pass (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire yrse_pkg::beat_t  beat_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output yrse_pkg::beat_t       beat_o
);

  logic [7:0]      alpha;
  logic [15:0]     mr, mg, mb;

  logic            a_v_q;
  yrse_pkg::beat_t a_beat_q;
  yrse_pkg::pix_t  a_s_q;
  logic            a_ready;

  logic            b_v_q;
  yrse_pkg::beat_t b_beat_q;
  logic            b_ready;

  logic [15:0]     xr, xg, xb;
  yrse_pkg::beat_t b_beat_d;

  assign b_ready = !b_v_q || ready_i;
  assign a_ready = !a_v_q || b_ready;
  assign ready_o = a_ready;

  assign alpha = 8'd255 - beat_i.pix.g;
  assign mr    = {8'd0, beat_i.pix.r} * {8'd0, alpha};
  assign mg    = {8'd0, beat_i.pix.g} * {8'd0, alpha};
  assign mb    = {8'd0, beat_i.pix.b} * {8'd0, alpha};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ready) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_beat_q <= beat_i;
      a_s_q.r  <= mr[15:8];
      a_s_q.g  <= mg[15:8];
      a_s_q.b  <= mb[15:8];
    end
  end

  assign xr = {8'd0, 8'd255 - a_beat_q.pix.r} * {8'd0, 8'd255 - a_s_q.r};
  assign xg = {8'd0, 8'd255 - a_beat_q.pix.g} * {8'd0, 8'd255 - a_s_q.g};
  assign xb = {8'd0, 8'd255 - a_beat_q.pix.b} * {8'd0, 8'd255 - a_s_q.b};

  always_comb begin
    b_beat_d = a_beat_q;
    if (a_beat_q.n != 2'd0) begin
      b_beat_d.pix.r = 8'd255 - xr[15:8];
      b_beat_d.pix.g = 8'd255 - xg[15:8];
      b_beat_d.pix.b = 8'd255 - xb[15:8];
      b_beat_d.n     = a_beat_q.n - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_v_q) begin
      b_beat_q <= b_beat_d;
    end
  end

  assign valid_o = b_v_q;
  assign beat_o  = b_beat_q;

endmodule
`default_nettype wire

>>> hw/rtl/ycbcr_to_rgb_screen_enhance.sv
// Pipeline: 2 conversion stages, then 2 stages for each of the two brightening pass units.
// Throughput: one pixel per cycle; each stage holds its word under stall
// and fills bubbles, so a stalled output blocks the input only once all six stages are full.
// Reset: async active low; clears all stage valid bits, passes_q = 2.
`default_nettype none
module ycbcr_to_rgb_screen_enhance (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  yrse_in_if.sink         pix_i,
  yrse_out_if.source      pix_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i
);

  logic [1:0]      passes_q;

  logic            csc_valid, p1_valid, p2_valid;
  logic            csc_ready, p1_ready;
  yrse_pkg::beat_t csc_beat, p1_beat, p2_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      passes_q <= yrse_pkg::PassesReset;
    end else if (cfg_we_i) begin
      passes_q <= cfg_wdata_i;
    end
  end

  yrse_csc u_csc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .passes_i(passes_q),
    .valid_o (csc_valid),
    .ready_i (csc_ready),
    .beat_o  (csc_beat)
  );

  yrse_pass u_pass1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(csc_valid),
    .ready_o(csc_ready),
    .beat_i (csc_beat),
    .valid_o(p1_valid),
    .ready_i(p1_ready),
    .beat_o (p1_beat)
  );

  yrse_pass u_pass2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(p1_valid),
    .ready_o(p1_ready),
    .beat_i (p1_beat),
    .valid_o(p2_valid),
    .ready_i(pix_o.ready),
    .beat_o (p2_beat)
  );

  assign pix_o.valid     = p2_valid;
  assign pix_o.red_out   = p2_beat.pix.r;
  assign pix_o.green_out = p2_beat.pix.g;
  assign pix_o.blue_out  = p2_beat.pix.b;

endmodule
`default_nettype wire

>>> hw/rtl/yrse_chk.sv
`default_nettype none
`include "ycbcr_to_rgb_screen_enhance_defines.svh"
module yrse_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_i,
  input wire logic [7:0] green_i,
  input wire logic [7:0] blue_i
);

  logic out_stall;

  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled word keeps valid and payload
  `YRSE_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i), "output word changed under stall")

  // with the sink taking words, every stage can advance
  `YRSE_ASSERT(a_ready_chain, clk_i, rst_ni, out_ready_i |-> in_ready_i, "input not ready while output drains")

  // output valid is low in the cycle after reset is seen asserted
  `YRSE_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i, "output valid right after reset")

  // no word is valid at the output in the cycle where reset release is first seen
  `YRSE_ASSERT(a_no_early, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid_i, "output valid at reset release")

endmodule

bind ycbcr_to_rgb_screen_enhance yrse_chk u_yrse_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (pix_i.ready),
  .out_valid_i(pix_o.valid),
  .out_ready_i(pix_o.ready),
  .red_i      (pix_o.red_out),
  .green_i    (pix_o.green_out),
  .blue_i     (pix_o.blue_out)
);
`default_nettype wire

>>> dv/ycbcr_to_rgb_screen_enhance_checker.sv
`default_nettype none
module ycbcr_to_rgb_screen_enhance_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  yrse_in_if              pix_in,
  yrse_out_if             pix_out,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  output int              pending_o,
  output int              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0]     passes = yrse_pkg::PassesReset;
  yrse_pkg::pix_t rgb_expected[$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // Q10 sum -> byte, C-style truncation toward zero then saturate
  function automatic int sat_q10(int sum);
    int q;
    q = sum / 1024;
    if (q < 0) return 0;
    if (q > 255) return 255;
    return q;
  endfunction

  function automatic yrse_pkg::pix_t predict_enhanced_pixel(logic [7:0] luma,
                                                            logic [7:0] cb,
                                                            logic [7:0] cr,
                                                            logic [1:0] npass);
    int             yy, u, v, rr, gg, bb, alpha, sr, sg, sb, runs;
    yrse_pkg::pix_t p;
    yy = int'(luma) - 16;
    u  = int'(cb) - 128;
    v  = int'(cr) - 128;
    rr = sat_q10(int'(yrse_pkg::QY) * yy + int'(yrse_pkg::QRV) * v);
    gg = sat_q10(int'(yrse_pkg::QY) * yy - int'(yrse_pkg::QGV) * v - int'(yrse_pkg::QGU) * u);
    bb = sat_q10(int'(yrse_pkg::QY) * yy + int'(yrse_pkg::QBU) * u);
    runs = (npass > yrse_pkg::PassesMax) ? int'(yrse_pkg::PassesMax) : int'(npass);
    for (int k = 0; k < runs; k++) begin
      // all channels share alpha from green at the start of the pass
      alpha = 255 - gg;
      sr = (rr * alpha) >> 8;
      sg = (gg * alpha) >> 8;
      sb = (bb * alpha) >> 8;
      rr = 255 - (((255 - rr) * (255 - sr)) >> 8);
      gg = 255 - (((255 - gg) * (255 - sg)) >> 8);
      bb = 255 - (((255 - bb) * (255 - sb)) >> 8);
    end
    p.r = rr[7:0];
    p.g = gg[7:0];
    p.b = bb[7:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t ns: %s: got %0d, want %0d", $realtime, what, got, want);
    errors_o = errors_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    yrse_pkg::pix_t want;
    if (!rst_ni) begin
      passes <= yrse_pkg::PassesReset;
    end else begin
      if (cfg_we_i) begin
        passes <= cfg_wdata_i;
      end
      if (pix_in.valid && pix_in.ready) begin
        rgb_expected.push_back(predict_enhanced_pixel(pix_in.luma, pix_in.chroma_blue,
                                                      pix_in.chroma_red, passes));
      end
      if (pix_out.valid && pix_out.ready) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch("output word with nothing pending, red", pix_out.red_out, 8'd0);
        end else begin
          want = rgb_expected.pop_front();
          if (pix_out.red_out !== want.r) report_mismatch("red", pix_out.red_out, want.r);
          if (pix_out.green_out !== want.g)
            report_mismatch("green", pix_out.green_out, want.g);
          if (pix_out.blue_out !== want.b) report_mismatch("blue", pix_out.blue_out, want.b);
        end
      end
      pending_o <= rgb_expected.size();
    end
  end

endmodule
`default_nettype wire

>>> dv/ycbcr_to_rgb_screen_enhance_tb.sv
`default_nettype none
module ycbcr_to_rgb_screen_enhance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases      = 5;
  localparam int RandomPerPhase = 110;
  localparam int LongHoldCycles = 60;
  localparam int DrainCycles    = 10;

  localparam logic [1:0] PhasePasses [NumPhases] =
    '{yrse_pkg::PassesReset, 2'd0, 2'd3, 2'd1, 2'd2};
  localparam int TxIdle [NumPhases] = '{28, 28, 88, 88, 0};
  localparam int RxIdle [NumPhases] = '{88, 88, 28, 28, 0};

  // {Y, Cb, Cr}: range corners, neutral grays, primaries and saturating mixes
  localparam logic [23:0] Directed [20] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FFFF, 24'h108080, 24'hEB8080,
    24'hEBF0F0, 24'h101010, 24'hFF00FF, 24'h00FF00, 24'hFFFF00, 24'h0000FF,
    24'h808080, 24'h515AF0, 24'h913622, 24'h29F06E, 24'hAAA610, 24'h6ACADE,
    24'hAA55AA, 24'h55AA55
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  int         tx_idle_pct;
  int         rx_idle_pct;
  logic       hold_req;
  logic       hold_seen;
  int         hold_left;
  int         pending;
  int         errors;

  yrse_in_if  pix_in ();
  yrse_out_if pix_out ();

  ycbcr_to_rgb_screen_enhance u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_in),
    .pix_o       (pix_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ycbcr_to_rgb_screen_enhance_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always #6 clk_i = ~clk_i;

  // output side: random backpressure, or a long counted hold when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= LongHoldCycles;
      pix_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid       <= 1'b1;
    pix_in.luma        <= luma;
    pix_in.chroma_blue <= cb;
    pix_in.chroma_red  <= cr;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_passes(logic [1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 2'd0;
    pix_in.valid       = 1'b0;
    pix_in.luma        = 8'd0;
    pix_in.chroma_blue = 8'd0;
    pix_in.chroma_red  = 8'd0;
    pix_out.ready      = 1'b0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    hold_req           = 1'b0;
    hold_seen          = 1'b0;
    hold_left          = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      // sender stops here until every word is back
      wait_drained();
      tx_idle_pct = TxIdle[ph];
      rx_idle_pct = RxIdle[ph];
      if (ph == 0) begin
        foreach (Directed[i]) send_pixel(Directed[i][23:16], Directed[i][15:8],
                                         Directed[i][7:0]);
      end else begin
        write_passes(PhasePasses[ph]);
      end
      if (ph == NumPhases - 1) hold_req <= ~hold_req;
      repeat (RandomPerPhase) send_pixel(pick_byte(), pick_byte(), pick_byte());
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
